>>> rtl/core/erd_pkg.sv
// Package for the entity reference decoder: item types, status codes,
// sizing constants and the named entity table. No dependencies.
`default_nettype none

package erd_pkg;

  // Longest name held before the entity is replayed as too long
  localparam int MAX_NAME     = 16;
  // Rows of the table that take part in matching
  localparam int ENTITY_COUNT = 58;
  localparam int TABLE_ROWS   = 54;
  localparam int ROWS         = (ENTITY_COUNT < TABLE_ROWS) ? ENTITY_COUNT : TABLE_ROWS;

  localparam int LEN_W  = $clog2(MAX_NAME + 1);
  localparam int ADDR_W = $clog2(MAX_NAME);

  localparam logic [15:0] CH_AMP  = 16'h0026;
  localparam logic [15:0] CH_SEMI = 16'h003B;
  localparam logic [15:0] CH_HASH = 16'h0023;
  localparam logic [15:0] CH_D0   = 16'h0030;
  localparam logic [15:0] CH_D9   = 16'h0039;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_UNTERM  = 2'd2,
    ST_LONG    = 2'd3
  } erd_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BODY,
    S_TAIL
  } erd_state_t;

  typedef struct packed {
    logic [15:0] char_code;
    logic        string_end;
  } erd_in_t;

  typedef struct packed {
    logic [15:0] out_char;
    erd_status_t status;
    logic        run_last;
    logic        out_string_end;
  } erd_out_t;

  // One step of the name matcher
  typedef struct packed {
    logic             start;
    logic             step;
    logic [15:0]      ch;
    logic [LEN_W-1:0] pos;
  } erd_mstep_t;

  // Names, right-aligned ASCII as written
  localparam logic [63:0] ENT_NAME [TABLE_ROWS] = '{
    "quot", "amp", "apos", "hyphen", "period",
    "mdash", "lsquo", "rsquo", "ldquo", "rdquo", "hellip",
    "copy", "reg", "trade", "bull", "sect", "ndash",
    "dagger", "micro", "para", "eacute", "Ccedil", "ccedil",
    "egrave", "nbsp", "shy", "deg", "radic", "check",
    "cross", "Delta", "alpha", "beta", "gamma", "delta",
    "lambda", "pi", "infin", "ne", "AElig", "aelig",
    "OElig", "oelig", "sup1", "sup2", "sup3", "frac14",
    "frac12", "frac34", "plusmn", "there4", "times", "divide",
    "euro"
  };

  localparam logic [15:0] ENT_CODE [TABLE_ROWS] = '{
    16'h0022, 16'h0026, 16'h0027, 16'h002D, 16'h002E,
    16'h2014, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2026,
    16'h00A9, 16'h00AE, 16'h2122, 16'h2022, 16'h00A7, 16'h2013,
    16'h2020, 16'h00B5, 16'h00B6, 16'h00E9, 16'h00C7, 16'h00E7,
    16'h00E8, 16'h00A0, 16'h00AD, 16'h00B0, 16'h221A, 16'h2713,
    16'h2717, 16'h2206, 16'h03B1, 16'h03B2, 16'h03B3, 16'h03B4,
    16'h03BB, 16'h03C0, 16'h221E, 16'h2260, 16'h00C6, 16'h00E6,
    16'h0152, 16'h0153, 16'h00B9, 16'h00B2, 16'h00B3, 16'h00BC,
    16'h00BD, 16'h00BE, 16'h00B1, 16'h2234, 16'h00D7, 16'h00F7,
    16'h20AC
  };

  // Reorder a right-aligned name so that its first character sits in byte 0
  function automatic logic [63:0] erd_norm(input logic [63:0] s);
    logic [63:0] t;
    int          n;
    t = '0;
    n = 0;
    for (int i = 0; i < 8; i++) begin
      if (s[8*i +: 8] != 8'd0) n = i + 1;
    end
    for (int i = 0; i < 8; i++) begin
      if (i < n) t[8*i +: 8] = s[8*(n-1-i) +: 8];
    end
    return t;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/erd_ram.sv
// Simple dual-port RAM with registered read data, one write and one read port.
// Standalone; holds the buffered entity name.
`default_nettype none

module erd_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/erd_match.sv
// Incremental name matcher: tracks per table row whether the name so far is
// a prefix of, or equal to, that row's name. Depends on erd_pkg.
`default_nettype none

module erd_match (
  input  logic               clk,
  input  logic               rst_n,
  input  erd_pkg::erd_mstep_t mstep,
  output logic               hit,
  output logic [15:0]        code
);
  import erd_pkg::*;

  logic [ROWS-1:0] pre_r;
  logic [ROWS-1:0] full_r;
  wire  [ROWS-1:0] pre_nxt;
  wire  [ROWS-1:0] full_nxt;
  wire  [15:0]     cand [ROWS];
  logic            pos_ok;
  logic [2:0]      pos3;
  logic [2:0]      pos_n;

  // Only the first seven positions can ever match
  assign pos_ok = mstep.pos < LEN_W'(7);
  assign pos3   = mstep.pos[2:0];
  assign pos_n  = pos3 + 3'd1;

  // Compare the new character against each row at the current position
  for (genvar r = 0; r < ROWS; r++) begin : g_row
    localparam logic [63:0] TXT = erd_norm(ENT_NAME[r]);
    wire [7:0] ch_here = TXT[8*pos3 +: 8];
    wire [7:0] ch_next = TXT[8*pos_n +: 8];
    wire       keep    = pre_r[r] && pos_ok && (ch_here != 8'd0) &&
                         (mstep.ch == {8'd0, ch_here});
    assign pre_nxt[r]  = mstep.start ? 1'b1 : (mstep.step ? keep : pre_r[r]);
    assign full_nxt[r] = mstep.start ? 1'b0 :
                         (mstep.step ? (keep && ch_next == 8'd0) : full_r[r]);
    assign cand[r]     = full_r[r] ? ENT_CODE[r] : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r  <= '0;
      full_r <= '0;
    end else begin
      pre_r  <= pre_nxt;
      full_r <= full_nxt;
    end
  end

  // At most one row is full, so OR the candidates together
  always_comb begin
    code = 16'd0;
    for (int r = 0; r < ROWS; r++) begin
      code = code | cand[r];
    end
  end

  assign hit = |full_r;

endmodule

`default_nettype wire

>>> rtl/core/entity_reference_decoder.sv
// Top level of the entity reference decoder. Depends on erd_pkg, erd_ram
// and erd_match.
`default_nettype none

// Decodes character entity references in a stream of 16-bit characters.
// Text characters and entities that resolve (named or '#'-decimal) give
// one result each. An '&' that opens an entity gives no result, and nor
// does each name character after it. A failed entity is replayed from the
// name buffer. '&' is loaded into the output register when the item that
// ends the entity is accepted. The first name character follows once the
// read is issued and the buffer's registered read port has returned it.
// After that the replay gives one result per cycle while the output is not
// stalled, and ends with the trailing ';' or overflow character if there is
// one. The input is stalled until the last result of the replay is loaded.
// The name buffer needs no clearing after reset, and the decoder takes
// items from the first cycle on.
module entity_reference_decoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  erd_pkg::erd_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output erd_pkg::erd_out_t out_item
);
  import erd_pkg::*;

  erd_state_t       state_r, state_nxt;
  logic             in_ent_r;
  logic [LEN_W-1:0] len_r;
  logic [15:0]      num_r;
  logic             num_ok_r;
  logic [LEN_W-1:0] rp_cnt_r;
  logic [LEN_W-1:0] rp_idx_r;
  logic             rd_vld_r;
  erd_status_t      rp_stat_r;
  logic [15:0]      rp_tail_r;
  logic             rp_has_tail_r;
  logic             rp_end_r;
  logic             out_vld_r;
  erd_out_t         out_r, out_nxt;

  logic             out_free, acc, take, rd_en, tail_go, last_entry, out_load;
  logic [15:0]      c;
  logic             e, is_amp, is_semi, is_digit, full;
  logic             act_enter, act_append, act_exit, act_emit, act_replay;
  logic [15:0]      emit_ch;
  erd_status_t      emit_st, rp_st;
  logic [15:0]      rp_tail;
  logic             rp_has_tail;
  logic [LEN_W-1:0] rp_cnt;
  logic [15:0]      rdata;
  logic             m_hit;
  logic [15:0]      m_code;
  erd_mstep_t       mstep;

  assign c          = in_item.char_code;
  assign e          = in_item.string_end;
  assign is_amp     = c == CH_AMP;
  assign is_semi    = c == CH_SEMI;
  assign is_digit   = (c >= CH_D0) && (c <= CH_D9);
  assign full       = len_r == LEN_W'(MAX_NAME);
  assign out_free   = !out_vld_r || !out_stall;
  assign acc        = in_valid && !in_stall;
  assign last_entry = rp_idx_r == rp_cnt_r;

  // Decode what an accepted item does
  always_comb begin
    act_enter   = 1'b0;
    act_append  = 1'b0;
    act_exit    = 1'b0;
    act_emit    = 1'b0;
    act_replay  = 1'b0;
    emit_ch     = c;
    emit_st     = ST_OK;
    rp_st       = ST_UNKNOWN;
    rp_tail     = CH_SEMI;
    rp_has_tail = 1'b1;
    rp_cnt      = len_r;
    if (!in_ent_r) begin
      if (is_amp && !e) begin
        act_enter = 1'b1;
      end else begin
        act_emit = 1'b1;
        emit_st  = is_amp ? ST_UNTERM : ST_OK;
      end
    end else if (is_semi) begin
      act_exit = 1'b1;
      if (len_r > LEN_W'(1) && num_ok_r) begin
        act_emit = 1'b1;
        emit_ch  = num_r;
      end else if (m_hit) begin
        act_emit = 1'b1;
        emit_ch  = m_code;
      end else begin
        act_replay = 1'b1;
      end
    end else if (full) begin
      act_exit   = 1'b1;
      act_replay = 1'b1;
      rp_st      = ST_LONG;
      rp_tail    = c;
    end else begin
      act_append = 1'b1;
      if (e) begin
        act_exit    = 1'b1;
        act_replay  = 1'b1;
        rp_st       = ST_UNTERM;
        rp_has_tail = 1'b0;
        rp_cnt      = len_r + LEN_W'(1);
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc && act_replay) state_nxt = (rp_cnt == '0) ? S_TAIL : S_BODY;
      end
      S_BODY: begin
        if (take && last_entry) state_nxt = rp_has_tail_r ? S_TAIL : S_IDLE;
      end
      S_TAIL: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall = 1'b1;
    take     = 1'b0;
    rd_en    = 1'b0;
    tail_go  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = !out_free;
      end
      S_BODY: begin
        take  = rd_vld_r && out_free;
        rd_en = !last_entry && (!rd_vld_r || take);
      end
      S_TAIL: begin
        tail_go = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Entity tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ent_r <= 1'b0;
      len_r    <= '0;
      num_r    <= 16'd0;
      num_ok_r <= 1'b1;
    end else if (acc) begin
      if (act_enter) begin
        in_ent_r <= 1'b1;
        len_r    <= '0;
        num_r    <= 16'd0;
        num_ok_r <= 1'b1;
      end
      if (act_exit) in_ent_r <= 1'b0;
      if (act_append) begin
        len_r <= len_r + LEN_W'(1);
        if (len_r == '0) begin
          num_ok_r <= c == CH_HASH;
          num_r    <= 16'd0;
        end else if (is_digit) begin
          num_r <= {num_r[12:0], 3'b000} + {num_r[14:0], 1'b0} + {12'd0, c[3:0]};
        end else begin
          num_ok_r <= 1'b0;
        end
      end
    end
  end

  // Replay bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      rp_idx_r <= '0;
      rp_cnt_r <= '0;
    end else begin
      if (acc && act_replay) begin
        rp_idx_r <= '0;
        rp_cnt_r <= rp_cnt;
      end else if (rd_en) begin
        rp_idx_r <= rp_idx_r + LEN_W'(1);
      end
      if (rd_en)     rd_vld_r <= 1'b1;
      else if (take) rd_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && act_replay) begin
      rp_stat_r     <= rp_st;
      rp_tail_r     <= rp_tail;
      rp_has_tail_r <= rp_has_tail;
      rp_end_r      <= e;
    end
  end

  // Name buffer
  erd_ram #(
    .DEPTH (MAX_NAME),
    .WIDTH (16)
  ) u_name_ram (
    .clk   (clk),
    .we    (acc && act_append),
    .waddr (len_r[ADDR_W-1:0]),
    .wdata (c),
    .re    (rd_en),
    .raddr (rp_idx_r[ADDR_W-1:0]),
    .rdata (rdata)
  );

  // Table matcher
  assign mstep.start = acc && act_enter;
  assign mstep.step  = acc && act_append;
  assign mstep.ch    = c;
  assign mstep.pos   = len_r;

  erd_match u_match (
    .clk   (clk),
    .rst_n (rst_n),
    .mstep (mstep),
    .hit   (m_hit),
    .code  (m_code)
  );

  // Select what goes into the output register
  always_comb begin
    out_load = 1'b0;
    out_nxt  = out_r;
    if (acc && act_replay) begin
      out_load = 1'b1;
      out_nxt  = erd_out_t'{out_char: CH_AMP, status: rp_st, run_last: 1'b0,
                            out_string_end: 1'b0};
    end else if (acc && act_emit) begin
      out_load = 1'b1;
      out_nxt  = erd_out_t'{out_char: emit_ch, status: emit_st, run_last: 1'b1,
                            out_string_end: e};
    end else if (take) begin
      out_load = 1'b1;
      out_nxt  = erd_out_t'{out_char: rdata, status: rp_stat_r,
                            run_last: last_entry && !rp_has_tail_r,
                            out_string_end: last_entry && !rp_has_tail_r && rp_end_r};
    end else if (tail_go) begin
      out_load = 1'b1;
      out_nxt  = erd_out_t'{out_char: rp_tail_r, status: rp_stat_r, run_last: 1'b1,
                            out_string_end: rp_end_r};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n)        out_vld_r <= 1'b0;
    else if (out_load) out_vld_r <= 1'b1;
    else if (!out_stall) out_vld_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

>>> rtl/core/erd_checker.sv
// Port-level checks for the entity reference decoder, bound to its top level.
// Depends on erd_pkg.
`default_nettype none

module erd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input erd_pkg::erd_out_t out_item
);
  import erd_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // Come out of reset with no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A decoded character always ends its item's results
  a_ok_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_OK |-> out_item.run_last)
    else $error("ok result not last of its item");

  // String end only marks the last result of an item
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.out_string_end |-> out_item.run_last)
    else $error("string end on a non-final result");

  // Take no new item while a replay is still in flight
  a_replay_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.run_last |-> in_stall)
    else $error("item taken during replay");

endmodule

bind entity_reference_decoder erd_checker u_erd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
